// ===== src/pbrs_pkg.sv =====
// shared constants, register codes and helpers for the pulse baseline removal scroller
package pbrs_pkg;

   localparam int unsigned WINDOW_LEN_DEFAULT = 256;
   localparam int unsigned COLUMNS_DEFAULT    = 8;

   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned ALPHA_W  = 17;
   localparam int unsigned LIMIT_W  = 8;
   localparam int unsigned NORM_W   = 17;
   localparam int unsigned LEVEL_W  = 5;
   localparam int unsigned COL_W    = 8;
   localparam int unsigned ADDR_W   = 3;
   localparam int unsigned DATA_W   = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd13107;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd20;

   typedef enum logic {
      REG_ALPHA = 1'b0,
      REG_LIMIT = 1'b1
   } csr_reg_type;

   // one-hot column byte, empty for negative levels, top bit for eight and above
   function automatic logic [COL_W-1:0] column_byte(input logic signed [LEVEL_W-1:0] lvl);
      logic [COL_W-1:0] col;
      if (lvl < 0) begin
         col = '0;
      end else if (lvl > 5'sd7) begin
         col = 8'h80;
      end else begin
         col = 8'h01 << lvl[2:0];
      end
      return col;
   endfunction

endpackage

// ===== src/pbrs_req_if.sv =====
// sample channel interface
interface pbrs_req_if import pbrs_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

// ===== src/pbrs_rsp_if.sv =====
// result channel interface
interface pbrs_rsp_if import pbrs_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic signed [NORM_W-1:0]  normalised_value;
   logic signed [LEVEL_W-1:0] level;
   logic                      scrolled;
   logic [COL_W-1:0]          column0;
   logic [COL_W-1:0]          column1;
   logic [COL_W-1:0]          column2;
   logic [COL_W-1:0]          column3;
   logic [COL_W-1:0]          column4;
   logic [COL_W-1:0]          column5;
   logic [COL_W-1:0]          column6;
   logic [COL_W-1:0]          column7;

   modport source (output valid, output normalised_value, output level, output scrolled,
                   output column0, output column1, output column2, output column3,
                   output column4, output column5, output column6, output column7,
                   input ready);
   modport sink   (input valid, input normalised_value, input level, input scrolled,
                   input column0, input column1, input column2, input column3,
                   input column4, input column5, input column6, input column7,
                   output ready);
endinterface

// ===== src/pbrs_delay_cell.sv =====
// one sample cell of the baseline window delay line
module pbrs_delay_cell import pbrs_pkg::*; #(
   parameter int unsigned WIDTH = VALUE_W
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in_sel;

   assign data_in_sel = enable ? data_in : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in_sel;
   end

   assign data_out = data_ff;

endmodule

// ===== src/pbrs_column_cell.sv =====
// one column cell of the scrolling display pattern
module pbrs_column_cell import pbrs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [COL_W-1:0] col_in,
   output logic [COL_W-1:0] col_out
);

   logic [COL_W-1:0] col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (enable) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

// ===== src/pbrs_divider.sv =====
// window average: window sum divided by the window length through a reciprocal
module pbrs_divider import pbrs_pkg::*; #(
   parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic [VALUE_W+$clog2(WINDOW_LEN)-1:0] sum_in,
   output logic [VALUE_W-1:0]                    quotient
);

   localparam int unsigned SUM_W  = VALUE_W + $clog2(WINDOW_LEN);
   localparam int unsigned RLO_W  = (SUM_W + 1) / 2;
   localparam int unsigned RHI_W  = SUM_W - RLO_W;
   localparam int unsigned PLO_W  = SUM_W + RLO_W;
   localparam int unsigned PHI_W  = SUM_W + RHI_W;
   localparam int unsigned TOT_W  = 2 * SUM_W;
   localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW_LEN);
   localparam logic [RLO_W-1:0] RECIP_LO = RECIP[RLO_W-1:0];
   localparam logic [RHI_W-1:0] RECIP_HI = RECIP[SUM_W-1:RLO_W];
   localparam logic [SUM_W-1:0] DIVISOR  = SUM_W'(WINDOW_LEN);

   logic [SUM_W-1:0]   sum_a_ff;
   logic [PLO_W-1:0]   plo_ff;
   logic [PHI_W-1:0]   phi_ff;
   logic [PLO_W-1:0]   plo_in;
   logic [PHI_W-1:0]   phi_in;
   logic [SUM_W-1:0]   sum_b_ff;
   logic [VALUE_W-1:0] qest_ff;
   logic [TOT_W-1:0]   total;
   logic [VALUE_W-1:0] qest_in;
   logic [SUM_W-1:0]   rem;
   logic [VALUE_W-1:0] quot_ff;
   logic [VALUE_W-1:0] quot_in;

   // partial products of the reciprocal
   assign plo_in = PLO_W'(sum_in) * PLO_W'(RECIP_LO);
   assign phi_in = PHI_W'(sum_in) * PHI_W'(RECIP_HI);

   // estimate is exact or one low
   assign total   = (TOT_W'(phi_ff) << RLO_W) + TOT_W'(plo_ff);
   assign qest_in = total[SUM_W+VALUE_W-1:SUM_W];

   assign rem     = sum_b_ff - SUM_W'(SUM_W'(qest_ff) * DIVISOR);
   assign quot_in = (rem >= DIVISOR) ? qest_ff + 1'b1 : qest_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_a_ff <= sum_in;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         sum_b_ff <= sum_a_ff;
         qest_ff  <= qest_in;
         quot_ff  <= quot_in;
      end
   end

   assign quotient = quot_ff;

endmodule

// ===== src/pulse_baseline_removal_scroller.sv =====
// top level of the pulse baseline removal scroller
//
// req_bus carries one 12-bit converter sample per transaction; rsp_bus returns
// exactly one result per sample, in order: the smoothed value minus the window
// baseline, its level from -7 to 7, a scroll flag and the eight display columns.
// a new sample can be taken every cycle while no result is stalled. the filter
// recurrence is a register fed back around one 18x17 multiplier; the window
// is a chain of sample cells with a running sum, and the average comes from a
// three-stage reciprocal divider.
// the baseline is zero until WINDOW_LEN samples have been taken.
// while rsp_bus holds a result that is not taken, the whole pipeline holds and
// req_bus.ready is low; it rises again in the cycle the result is taken.
// the csr port writes alpha_weight at byte address 0 and scroll_limit at 4;
// the user must do so only while no transaction is in flight: the block does
// not enforce it. reset clears the filter, the running sum, the fill and scroll
// counts, the display pattern and the registers to their defaults.
module pulse_baseline_removal_scroller import pbrs_pkg::*; #(
   parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEFAULT,
   parameter int unsigned COLUMNS    = COLUMNS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   pbrs_req_if.sink          req_bus,
   pbrs_rsp_if.source        rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int unsigned SUM_W  = VALUE_W + $clog2(WINDOW_LEN);
   localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);

   // csr
   logic [ALPHA_W-1:0] alpha_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               csr_write;
   csr_reg_type        csr_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_sel)
         REG_ALPHA: csr_prdata = DATA_W'(alpha_ff);
         REG_LIMIT: csr_prdata = DATA_W'(limit_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_ALPHA: alpha_ff <= csr_pwdata[ALPHA_W-1:0];
            REG_LIMIT: limit_ff <= csr_pwdata[LIMIT_W-1:0];
            default:   alpha_ff <= alpha_ff;
         endcase
      end
   end

   // pipeline control
   logic advance;
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v0_ff        <= req_bus.valid;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   // sample scaling to q0.16: 16*adc + round((15*adc)/4095)
   logic [VALUE_W-1:0] scale_num;
   logic [3:0]         scale_q0;
   logic [12:0]        scale_rem;
   logic [VALUE_W-1:0] x_in;
   logic [VALUE_W-1:0] x0_ff;

   assign scale_num = VALUE_W'(req_bus.adc_sample) * 16'd15 + 16'd2047;
   assign scale_q0  = scale_num[15:12];
   assign scale_rem = 13'(scale_num[11:0]) + 13'(scale_q0);
   assign x_in      = {req_bus.adc_sample, 4'b0000} + VALUE_W'(scale_q0)
                      + VALUE_W'(scale_rem >= 13'd4095);

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff <= x_in;
      end
   end

   // first-order low-pass: f + ((a*(x-f) + half) >>> 16)
   logic [ALPHA_W-1:0]        alpha_eff;
   logic signed [VALUE_W:0]   filt_diff;
   logic signed [34:0]        filt_prod;
   logic signed [34:0]        filt_round;
   logic [VALUE_W-1:0]        filt_ff;
   logic [VALUE_W-1:0]        filt_in;

   assign alpha_eff  = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign filt_diff  = $signed({1'b0, x0_ff}) - $signed({1'b0, filt_ff});
   assign filt_prod  = $signed({1'b0, alpha_eff}) * filt_diff;
   assign filt_round = filt_prod + 35'sd32768;
   assign filt_in    = filt_ff + filt_round[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
      end else if (advance && v0_ff) begin
         filt_ff <= filt_in;
      end
   end

   // window delay line of sample cells
   logic [VALUE_W-1:0] win_tap [WINDOW_LEN];
   logic               win_shift;

   assign win_shift = advance && v1_ff;

   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_window
      if (i == 0) begin : g_head
         pbrs_delay_cell #(.WIDTH(VALUE_W)) u_cell (
            .clock    (clock),
            .enable   (win_shift),
            .data_in  (filt_ff),
            .data_out (win_tap[i])
         );
      end else begin : g_body
         pbrs_delay_cell #(.WIDTH(VALUE_W)) u_cell (
            .clock    (clock),
            .enable   (win_shift),
            .data_in  (win_tap[i-1]),
            .data_out (win_tap[i])
         );
      end
   end

   // running sum and fill count
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;
   logic [VALUE_W-1:0] tail_eff;
   logic [FILL_W-1:0]  fill_ff;
   logic               full_in;
   logic [VALUE_W-1:0] f2_ff, f3_ff, f4_ff, f5_ff;
   logic               full2_ff, full3_ff, full4_ff, full5_ff;

   assign tail_eff = (fill_ff == FILL_W'(WINDOW_LEN)) ? win_tap[WINDOW_LEN-1] : '0;
   assign sum_in   = sum_ff - SUM_W'(tail_eff) + SUM_W'(filt_ff);
   assign full_in  = (fill_ff >= FILL_W'(WINDOW_LEN - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         fill_ff <= '0;
      end else if (win_shift) begin
         sum_ff <= sum_in;
         if (fill_ff != FILL_W'(WINDOW_LEN)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f2_ff    <= filt_ff;
         full2_ff <= full_in;
         f3_ff    <= f2_ff;
         full3_ff <= full2_ff;
         f4_ff    <= f3_ff;
         full4_ff <= full3_ff;
         f5_ff    <= f4_ff;
         full5_ff <= full4_ff;
      end
   end

   // window average
   logic [VALUE_W-1:0] avg;

   pbrs_divider #(.WINDOW_LEN(WINDOW_LEN)) u_divider (
      .clock    (clock),
      .enable   (advance),
      .sum_in   (sum_ff),
      .quotient (avg)
   );

   // normalise, level, scroll
   logic [VALUE_W-1:0]         baseline;
   logic signed [NORM_W-1:0]   norm;
   logic [NORM_W-1:0]          norm_mag;
   logic [2:0]                 lvl_mag;
   logic signed [LEVEL_W-1:0]  level;
   logic [LIMIT_W-1:0]         scroll_ff;
   logic                       do_scroll;
   logic                       col_shift;
   logic [COL_W-1:0]           new_col;
   logic signed [NORM_W-1:0]   norm_ff;
   logic signed [LEVEL_W-1:0]  level_ff;
   logic                       scrolled_ff;

   assign baseline  = full5_ff ? avg : '0;
   assign norm      = $signed({1'b0, f5_ff}) - $signed({1'b0, baseline});
   assign norm_mag  = norm[NORM_W-1] ? NORM_W'(-norm) : NORM_W'(norm);
   assign lvl_mag   = norm_mag[15:13];
   assign level     = norm[NORM_W-1] ? $signed(5'd0 - {2'b00, lvl_mag})
                                     : $signed({2'b00, lvl_mag});
   assign new_col   = column_byte(level);
   assign do_scroll = (scroll_ff >= limit_ff);
   assign col_shift = advance && v5_ff && do_scroll;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_ff <= '0;
      end else if (advance && v5_ff) begin
         scroll_ff <= do_scroll ? '0 : scroll_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         norm_ff     <= norm;
         level_ff    <= level;
         scrolled_ff <= do_scroll;
      end
   end

   // display pattern: column 0 oldest, newest enters at the top cell
   logic [COL_W-1:0] col_tap [COLUMNS];
   logic [COL_W-1:0] col_out [8];

   for (genvar c = 0; c < COLUMNS; c++) begin : g_columns
      if (c == COLUMNS - 1) begin : g_newest
         pbrs_column_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .enable  (col_shift),
            .col_in  (new_col),
            .col_out (col_tap[c])
         );
      end else begin : g_older
         pbrs_column_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .enable  (col_shift),
            .col_in  (col_tap[c+1]),
            .col_out (col_tap[c])
         );
      end
   end

   for (genvar c = 0; c < 8; c++) begin : g_col_out
      if (c < COLUMNS) begin : g_used
         assign col_out[c] = col_tap[c];
      end else begin : g_unused
         assign col_out[c] = '0;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.normalised_value = norm_ff;
   assign rsp_bus.level            = level_ff;
   assign rsp_bus.scrolled         = scrolled_ff;
   assign rsp_bus.column0          = col_out[0];
   assign rsp_bus.column1          = col_out[1];
   assign rsp_bus.column2          = col_out[2];
   assign rsp_bus.column3          = col_out[3];
   assign rsp_bus.column4          = col_out[4];
   assign rsp_bus.column5          = col_out[5];
   assign rsp_bus.column6          = col_out[6];
   assign rsp_bus.column7          = col_out[7];

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_LEN))
      else $error("fill count beyond window length");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("sample taken while a result is stalled");

   a_scroll_resets_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && scrolled_ff |-> scroll_ff == '0)
      else $error("scroll count not cleared after a scroll");

   a_level_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && level_ff[LEVEL_W-1] |-> norm_ff[NORM_W-1])
      else $error("negative level for a non-negative value");

   a_no_baseline_early: assert property (@(posedge clock) disable iff (reset)
      v2_ff && (fill_ff != FILL_W'(WINDOW_LEN)) |-> !full2_ff)
      else $error("baseline enabled before the window is full");
`endif

endmodule
